>>> design/fwrc_pkg.sv
`default_nettype none
package fwrc_pkg;

  typedef enum logic [2:0] {
    OP_PACKET = 3'd0,
    OP_APPEND_TERM = 3'd1,
    OP_APPEND_RET = 3'd2,
    OP_APPEND_LOG = 3'd3,
    OP_FLUSH = 3'd4,
    OP_ZERO = 3'd5,
    OP_LIST = 3'd6,
    OP_NONE = 3'd7
  } op_t;

  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_TOTALS = 2'd2;
  localparam logic [1:0] KIND_RULE = 2'd3;

  localparam logic [1:0] ST_TERM = 2'd0;
  localparam logic [1:0] ST_RETURN = 2'd1;
  localparam logic [1:0] ST_END = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [1:0] TGT_RETURN = 2'd2;
  localparam logic [1:0] TGT_LOG = 2'd3;

  localparam logic [5:0] PREFIX_ANY = 6'd63;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  chain_select;
    logic [7:0]  in_if;
    logic [7:0]  out_if;
    logic [7:0]  proto_id;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] length;
    logic [6:0]  src_match;
    logic [6:0]  dst_match;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  rule_index;
    logic [31:0] packet_total;
    logic [31:0] byte_total;
    logic [1:0]  status;
    logic        last;
  } out_word_t;

  // rule body: key 56, networks 64, modes 16
  localparam int RULE_W = 136;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // capture input word
    logic hit_upd;    // write rule counters with hit values
    logic wr_new;     // write new rule
    logic clr_rule;   // zero rule counters at scan index
    logic chain_add;  // add packet to chain counters
    logic chain_clr;  // zero chain counters
    logic count_clr;  // zero chain rule count
    logic count_inc;  // bump chain rule count
    logic idx_clr;
    logic idx_inc;
    logic emit;
    logic [1:0] kind;
    logic [1:0] status;
    logic use_rule;   // output rule counters vs chain
    logic zero_cnt;   // output zero counters
    logic idx_none;
    logic last;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    op_t        op;
    logic       at_end;   // scan index reached chain count
    logic       full;
    logic       match;
    logic [1:0] tgt;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

>>> design/fwrc_ram.sv
`default_nettype none
module fwrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/fwrc_datapath.sv
`default_nettype none
module fwrc_datapath #(
  parameter int RULES_PER_CHAIN = 16,
  parameter int ID_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fwrc_pkg::in_word_t   in_word,
  input  wire fwrc_pkg::cmd_t       cmd,
  output fwrc_pkg::sts_t            sts,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output fwrc_pkg::out_word_t       out_word
);
  localparam int IW = $clog2(RULES_PER_CHAIN + 1);
  localparam int AW = $clog2(3 * RULES_PER_CHAIN);
  localparam int RW = (RULES_PER_CHAIN > 1) ? $clog2(RULES_PER_CHAIN) : 1;
  localparam logic [IW-1:0] NRULES = IW'(RULES_PER_CHAIN);
  localparam logic [7:0] ID_MASK = 8'((1 << ID_BITS) - 1);

  fwrc_pkg::in_word_t w_r;
  logic [1:0] chain_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] cnt_r [3];
  logic [31:0] cpk_r [3];
  logic [31:0] cby_r [3];
  logic [31:0] hpk_r, hby_r;
  logic out_valid_r;
  fwrc_pkg::out_word_t out_r;

  // fields with ids masked to ID_BITS
  logic [7:0] ii, oi, pi;
  assign ii = w_r.in_if & ID_MASK;
  assign oi = w_r.out_if & ID_MASK;
  assign pi = w_r.proto_id & ID_MASK;

  logic [1:0] chain_nxt;
  logic [7:0] lii, loi;
  assign lii = in_word.in_if & ID_MASK;
  assign loi = in_word.out_if & ID_MASK;
  always_comb begin
    if (in_word.operation == fwrc_pkg::OP_PACKET) begin
      chain_nxt = (loi == 8'd0) ? 2'd0 : ((lii == 8'd0) ? 2'd1 : 2'd2);
    end else begin
      chain_nxt = (in_word.chain_select == 2'd3) ? 2'd2 : in_word.chain_select;
    end
  end

  // memory address: chain base plus slot; an append goes to the slot after the last rule
  logic [IW-1:0] pos;
  logic [AW-1:0] addr;
  logic [RW-1:0] slot;
  assign pos = cmd.wr_new ? cnt_r[chain_r] : idx_r;
  assign slot = RW'(pos);
  assign addr = AW'(chain_r) * AW'(RULES_PER_CHAIN) + AW'(slot);

  logic [fwrc_pkg::RULE_W-1:0] rule_wdata, rule_rdata;
  assign rule_wdata = {ii, oi, pi, w_r.src_port, w_r.dst_port, w_r.src_addr, w_r.dst_addr,
                       w_r.operation[1:0], w_r.dst_match, w_r.src_match};

  fwrc_ram #(.WIDTH(fwrc_pkg::RULE_W), .DEPTH(3 * RULES_PER_CHAIN)) u_rules (
    .clk(clk), .we(cmd.wr_new), .waddr(addr), .wdata(rule_wdata),
    .raddr(addr), .rdata(rule_rdata)
  );

  logic [63:0] ctr_wdata, ctr_rdata;
  logic ctr_we;
  assign ctr_we = cmd.hit_upd | cmd.wr_new | cmd.clr_rule;
  assign ctr_wdata = cmd.hit_upd ? {hpk_r, hby_r} : 64'd0;

  fwrc_ram #(.WIDTH(64), .DEPTH(3 * RULES_PER_CHAIN)) u_ctrs (
    .clk(clk), .we(ctr_we), .waddr(addr), .wdata(ctr_wdata),
    .raddr(addr), .rdata(ctr_rdata)
  );

  // rule match on the read rule
  logic [7:0] k_i, k_o, k_p;
  logic [15:0] k_sp, k_dp;
  logic [31:0] n_s, n_d;
  logic [1:0] tgt;
  logic [6:0] m_s, m_d;
  assign {k_i, k_o, k_p, k_sp, k_dp, n_s, n_d, tgt, m_d, m_s} = rule_rdata;

  function automatic logic addr_ok(input logic [31:0] net, input logic [6:0] m,
                                   input logic [31:0] a);
    logic [5:0] p;
    logic [31:0] mask;
    p = m[5:0];
    if (p >= 6'd32) mask = 32'hFFFF_FFFF;
    else if (p == 6'd0) mask = 32'd0;
    else mask = 32'hFFFF_FFFF << (6'd32 - p);
    if (p == fwrc_pkg::PREFIX_ANY) return 1'b1;
    return m[6] ^ (net == (a & mask));
  endfunction

  logic match;
  assign match = (k_i == 8'd0 || k_i == ii) && (k_o == 8'd0 || k_o == oi) &&
                 (k_p == 8'd0 || k_p == pi) && (k_sp == 16'd0 || k_sp == w_r.src_port) &&
                 (k_dp == 16'd0 || k_dp == w_r.dst_port) &&
                 addr_ok(n_s, m_s, w_r.src_addr) && addr_ok(n_d, m_d, w_r.dst_addr);

  always_comb begin
    sts.op = fwrc_pkg::op_t'(w_r.operation);
    sts.at_end = (idx_r >= cnt_r[chain_r]) || (idx_r >= NRULES);
    sts.full = (cnt_r[chain_r] >= NRULES);
    sts.match = match;
    sts.tgt = tgt;
    sts.out_busy = out_valid_r & ~out_ready;
  end

  // capture word, hit counters, scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r <= in_word;
      chain_r <= chain_nxt;
    end
    hpk_r <= ctr_rdata[63:32] + 32'd1;
    hby_r <= ctr_rdata[31:0] + 32'(w_r.length);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      for (int c = 0; c < 3; c++) begin
        cnt_r[c] <= '0;
        cpk_r[c] <= '0;
        cby_r[c] <= '0;
      end
    end else begin
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + IW'(1);
      if (cmd.count_clr) cnt_r[chain_r] <= '0;
      else if (cmd.count_inc) cnt_r[chain_r] <= cnt_r[chain_r] + IW'(1);
      if (cmd.chain_clr) begin
        cpk_r[chain_r] <= '0;
        cby_r[chain_r] <= '0;
      end else if (cmd.chain_add) begin
        cpk_r[chain_r] <= cpk_r[chain_r] + 32'd1;
        cby_r[chain_r] <= cby_r[chain_r] + 32'(w_r.length);
      end
    end
  end

  // output register
  fwrc_pkg::out_word_t out_nxt;
  always_comb begin
    out_nxt.kind = cmd.kind;
    out_nxt.status = cmd.status;
    out_nxt.last = cmd.last;
    out_nxt.rule_index = cmd.idx_none ? 5'(RULES_PER_CHAIN) : 5'(pos);
    if (cmd.zero_cnt) begin
      out_nxt.packet_total = '0;
      out_nxt.byte_total = '0;
    end else if (cmd.use_rule) begin
      out_nxt.packet_total = (cmd.kind == fwrc_pkg::KIND_RULE) ? ctr_rdata[63:32] : hpk_r;
      out_nxt.byte_total = (cmd.kind == fwrc_pkg::KIND_RULE) ? ctr_rdata[31:0] : hby_r;
    end else begin
      out_nxt.packet_total = cpk_r[chain_r];
      out_nxt.byte_total = cby_r[chain_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word = out_r;

  // emit only into a free output slot
  assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> !sts.out_busy)
    else $error("emit over pending word");
  // chain count never exceeds the table
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r[chain_r] <= NRULES)
    else $error("rule count overflow");
  // appends only below capacity
  assert property (@(posedge clk) disable iff (!rst_n) cmd.wr_new |-> !sts.full)
    else $error("append into full chain");
endmodule
`default_nettype wire

>>> design/fwrc_ctrl.sv
`default_nettype none
module fwrc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire fwrc_pkg::sts_t  sts,
  output fwrc_pkg::cmd_t       cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RD, S_WAIT, S_CHK, S_HIT, S_MISS, S_ZERO,
    S_LRD, S_LWAIT, S_LEMIT, S_TOT
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] tgt_r, tgt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    tgt_nxt = tgt_r;
    cmd = '0;
    cmd.kind = fwrc_pkg::KIND_TOTALS;
    cmd.status = fwrc_pkg::ST_TERM;
    cmd.last = 1'b1;
    case (state_r)
      S_IDLE: begin
        cmd.load = 1'b1;
        cmd.idx_clr = 1'b1;
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.op)
          fwrc_pkg::OP_PACKET: state_nxt = S_RD;
          fwrc_pkg::OP_APPEND_TERM, fwrc_pkg::OP_APPEND_RET,
          fwrc_pkg::OP_APPEND_LOG: begin
            if (!sts.out_busy) begin
              cmd.emit = 1'b1;
              cmd.kind = fwrc_pkg::KIND_APPEND;
              cmd.zero_cnt = 1'b1;
              if (sts.full) begin
                cmd.status = fwrc_pkg::ST_FULL;
                cmd.idx_none = 1'b1;
              end else begin
                cmd.wr_new = 1'b1;
                cmd.count_inc = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end
          fwrc_pkg::OP_FLUSH: begin
            if (!sts.out_busy) begin
              cmd.emit = 1'b1;
              cmd.zero_cnt = 1'b1;
              cmd.idx_none = 1'b1;
              cmd.count_clr = 1'b1;
              cmd.chain_clr = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          fwrc_pkg::OP_ZERO: state_nxt = S_ZERO;
          fwrc_pkg::OP_LIST: state_nxt = S_LRD;
          default: state_nxt = S_IDLE;
        endcase
      end
      // scan: address settles, read, check
      S_RD: begin
        if (sts.at_end) state_nxt = S_MISS;
        else state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_CHK;
      S_CHK: begin
        if (sts.match) begin
          tgt_nxt = sts.tgt;
          state_nxt = S_HIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_HIT: begin
        if (tgt_r == fwrc_pkg::TGT_LOG) begin
          cmd.hit_upd = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt = S_RD;
        end else if (!sts.out_busy) begin
          cmd.hit_upd = 1'b1;
          cmd.emit = 1'b1;
          cmd.kind = fwrc_pkg::KIND_VERDICT;
          cmd.use_rule = 1'b1;
          if (tgt_r == fwrc_pkg::TGT_RETURN) begin
            cmd.status = fwrc_pkg::ST_RETURN;
            cmd.chain_add = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_MISS: begin
        cmd.chain_add = 1'b1;
        state_nxt = S_TOT;
        tgt_nxt = fwrc_pkg::ST_END;
      end
      // zero rule counters one slot per cycle
      S_ZERO: begin
        if (sts.at_end) begin
          cmd.chain_clr = 1'b1;
          state_nxt = S_TOT;
          tgt_nxt = fwrc_pkg::ST_TERM;
        end else begin
          cmd.clr_rule = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_LRD: begin
        if (sts.at_end) begin
          state_nxt = S_TOT;
          tgt_nxt = fwrc_pkg::ST_TERM;
        end else state_nxt = S_LWAIT;
      end
      S_LWAIT: state_nxt = S_LEMIT;
      S_LEMIT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.kind = fwrc_pkg::KIND_RULE;
          cmd.use_rule = 1'b1;
          cmd.last = 1'b0;
          cmd.idx_inc = 1'b1;
          state_nxt = S_LRD;
        end
      end
      S_TOT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          cmd.kind = (tgt_r == fwrc_pkg::ST_END) ? fwrc_pkg::KIND_VERDICT
                                                 : fwrc_pkg::KIND_TOTALS;
          cmd.status = tgt_r;
          cmd.idx_none = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tgt_r <= '0;
    end else begin
      state_r <= state_nxt;
      tgt_r <= tgt_nxt;
    end
  end

  // a word is taken only in idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_DECODE)
    else $error("accept did not start decode");
  // new rule written only from decode
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_new |-> state_r == S_DECODE)
    else $error("stray rule write");
  // counter update only on a hit
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hit_upd |-> state_r == S_HIT)
    else $error("hit update without match");
endmodule
`default_nettype wire

>>> design/firewall_rule_chain_classifier_core.sv
// Firewall rule-chain classifier.
// Input channel in_valid/in_ready carries one in_word per operation: a packet
// to classify, or an append, flush, zero or list command on one chain.
// Output channel out_valid/out_ready returns result words; each operation
// gives one word except list, which gives one per rule then the chain totals,
// with last set on the final word, and the unused op code, which gives none.
// A packet reads its chain's rules from a rule memory one at a time, each
// by address, registered read and compare, plus a counter update for each
// LOG match.
// The block takes one word at a time; in_ready is high only when idle, which
// is the cycle after the final result word is loaded.
// A stalled receiver holds the output register and the sequencer waits
// before writing the next result.
// Reset (rst_n low, synchronous) clears chain counts and chain counters; rule
// and counter memories need no clearing since only appended rules are read.
`default_nettype none
module firewall_rule_chain_classifier_core #(
  parameter int RULES_PER_CHAIN = 16,
  parameter int ID_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fwrc_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fwrc_pkg::out_word_t      out_word
);
  fwrc_pkg::cmd_t cmd;
  fwrc_pkg::sts_t sts;

  fwrc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  fwrc_datapath #(.RULES_PER_CHAIN(RULES_PER_CHAIN), .ID_BITS(ID_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_word), .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );
endmodule
`default_nettype wire

>>> sim/firewall_rule_chain_classifier_core_tb.sv
`default_nettype none
module firewall_rule_chain_classifier_core_tb;

  localparam int NRULE = 16;
  localparam int NCH = 3;
  localparam logic [4:0] NO_IDX = 5'(NRULE);
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  fwrc_pkg::in_word_t in_word;
  logic out_valid;
  logic out_ready;
  fwrc_pkg::out_word_t out_word;

  firewall_rule_chain_classifier_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  // shadow rule tables
  logic [55:0] sh_key [NCH*NRULE];
  logic [63:0] sh_net [NCH*NRULE];
  logic [15:0] sh_mode [NCH*NRULE];
  logic [31:0] sh_rpk [NCH*NRULE];
  logic [31:0] sh_rby [NCH*NRULE];
  logic [31:0] sh_cpk [NCH];
  logic [31:0] sh_cby [NCH];
  int sh_cnt [NCH];

  fwrc_pkg::out_word_t pending_words[$];
  int errors;
  int cycles;
  int send_idle_pct;
  int recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void queue_result(fwrc_pkg::out_word_t r);
    pending_words.insert(pending_words.size(), r);
  endfunction

  function automatic logic [31:0] prefix_mask(logic [5:0] p);
    if (p >= 6'd32) return 32'hFFFF_FFFF;
    if (p == 6'd0) return 32'h0;
    return 32'hFFFF_FFFF << (32 - p);
  endfunction

  function automatic bit addr_hit(logic [31:0] net, logic [6:0] m, logic [31:0] a);
    if (m[5:0] == fwrc_pkg::PREFIX_ANY) return 1'b1;
    if (m[6]) return net != (a & prefix_mask(m[5:0]));
    return net == (a & prefix_mask(m[5:0]));
  endfunction

  function automatic bit rule_hit(int slot, fwrc_pkg::in_word_t w);
    logic [55:0] k;
    k = sh_key[slot];
    if (k[55:48] != 0 && k[55:48] != w.in_if) return 1'b0;
    if (k[47:40] != 0 && k[47:40] != w.out_if) return 1'b0;
    if (k[39:32] != 0 && k[39:32] != w.proto_id) return 1'b0;
    if (k[31:16] != 0 && k[31:16] != w.src_port) return 1'b0;
    if (k[15:0] != 0 && k[15:0] != w.dst_port) return 1'b0;
    if (!addr_hit(sh_net[slot][63:32], sh_mode[slot][6:0], w.src_addr)) return 1'b0;
    return addr_hit(sh_net[slot][31:0], sh_mode[slot][13:7], w.dst_addr);
  endfunction

  function automatic fwrc_pkg::out_word_t mk(logic [1:0] k, logic [4:0] ix, logic [31:0] p,
                                             logic [31:0] b, logic [1:0] s, logic l);
    fwrc_pkg::out_word_t r;
    r.kind = k; r.rule_index = ix; r.packet_total = p;
    r.byte_total = b; r.status = s; r.last = l;
    return r;
  endfunction

  // classify or apply one command, queue resulting words
  task automatic predict_op(fwrc_pkg::in_word_t w);
    int c;
    int base;
    int slot;
    logic [1:0] tgt;
    c = (w.chain_select > 2) ? 2 : int'(w.chain_select);
    if (w.operation == fwrc_pkg::OP_PACKET) begin
      c = (w.out_if == 0) ? 0 : ((w.in_if == 0) ? 1 : 2);
      base = c * NRULE;
      for (int i = 0; i < sh_cnt[c]; i++) begin
        slot = base + i;
        if (rule_hit(slot, w)) begin
          sh_rpk[slot] += 1;
          sh_rby[slot] += w.length;
          tgt = sh_mode[slot][15:14];
          if (tgt == fwrc_pkg::TGT_RETURN) begin
            sh_cpk[c] += 1;
            sh_cby[c] += w.length;
          end
          if (tgt != fwrc_pkg::TGT_LOG) begin
            queue_result(mk(fwrc_pkg::KIND_VERDICT, 5'(i), sh_rpk[slot], sh_rby[slot],
                            (tgt == fwrc_pkg::TGT_RETURN) ? fwrc_pkg::ST_RETURN
                                                          : fwrc_pkg::ST_TERM, 1'b1));
            return;
          end
        end
      end
      sh_cpk[c] += 1;
      sh_cby[c] += w.length;
      queue_result(mk(fwrc_pkg::KIND_VERDICT, NO_IDX, sh_cpk[c], sh_cby[c],
                      fwrc_pkg::ST_END, 1'b1));
      return;
    end
    base = c * NRULE;
    case (w.operation)
      fwrc_pkg::OP_APPEND_TERM, fwrc_pkg::OP_APPEND_RET, fwrc_pkg::OP_APPEND_LOG: begin
        if (sh_cnt[c] >= NRULE) begin
          queue_result(mk(fwrc_pkg::KIND_APPEND, NO_IDX, '0, '0, fwrc_pkg::ST_FULL, 1'b1));
        end else begin
          slot = base + sh_cnt[c];
          sh_key[slot] = {w.in_if, w.out_if, w.proto_id, w.src_port, w.dst_port};
          sh_net[slot] = {w.src_addr, w.dst_addr};
          sh_mode[slot] = {w.operation[1:0], w.dst_match, w.src_match};
          sh_rpk[slot] = '0;
          sh_rby[slot] = '0;
          queue_result(mk(fwrc_pkg::KIND_APPEND, 5'(sh_cnt[c]), '0, '0,
                          fwrc_pkg::ST_TERM, 1'b1));
          sh_cnt[c]++;
        end
      end
      fwrc_pkg::OP_FLUSH, fwrc_pkg::OP_ZERO: begin
        if (w.operation == fwrc_pkg::OP_FLUSH) sh_cnt[c] = 0;
        else
          for (int i = 0; i < sh_cnt[c]; i++) begin
            sh_rpk[base+i] = '0;
            sh_rby[base+i] = '0;
          end
        sh_cpk[c] = '0;
        sh_cby[c] = '0;
        queue_result(mk(fwrc_pkg::KIND_TOTALS, NO_IDX, '0, '0, fwrc_pkg::ST_TERM, 1'b1));
      end
      fwrc_pkg::OP_LIST: begin
        for (int i = 0; i < sh_cnt[c]; i++)
          queue_result(mk(fwrc_pkg::KIND_RULE, 5'(i), sh_rpk[base+i], sh_rby[base+i],
                          fwrc_pkg::ST_TERM, 1'b0));
        queue_result(mk(fwrc_pkg::KIND_TOTALS, NO_IDX, sh_cpk[c], sh_cby[c],
                        fwrc_pkg::ST_TERM, 1'b1));
      end
      default: ;
    endcase
  endtask

  // check each accepted result word against the oldest expectation
  always @(posedge clk) begin
    fwrc_pkg::out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word %h", out_word);
        errors++;
      end else begin
        e = pending_words.pop_front();
        if (out_word.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_word.kind); errors++;
        end
        if (out_word.rule_index !== e.rule_index) begin
          $error("rule_index exp %0d got %0d", e.rule_index, out_word.rule_index); errors++;
        end
        if (out_word.packet_total !== e.packet_total) begin
          $error("packet_total exp %0d got %0d", e.packet_total, out_word.packet_total);
          errors++;
        end
        if (out_word.byte_total !== e.byte_total) begin
          $error("byte_total exp %0d got %0d", e.byte_total, out_word.byte_total); errors++;
        end
        if (out_word.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_word.status); errors++;
        end
        if (out_word.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_word.last); errors++;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // drive one word, wait for acceptance; a typed result replaces the predicted one
  task automatic send_word(fwrc_pkg::in_word_t w, bit chk, fwrc_pkg::out_word_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    predict_op(w);
    if (chk) pending_words[pending_words.size() - 1] = want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and hold until every expected word is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic fwrc_pkg::in_word_t rand_word();
    logic [159:0] raw;
    fwrc_pkg::in_word_t w;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(fwrc_pkg::in_word_t)-1:0];
    return w;
  endfunction

  // packet/rule biased toward hits: small id alphabet, wildcards common
  function automatic fwrc_pkg::in_word_t shaped_word(logic [2:0] op);
    fwrc_pkg::in_word_t w;
    w = rand_word();
    w.operation = op;
    w.chain_select = 2'($urandom_range(3));
    w.in_if = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(3));
    w.out_if = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(3));
    w.proto_id = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(2));
    w.src_port = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(2));
    w.dst_port = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(2));
    if (op != fwrc_pkg::OP_PACKET && $urandom_range(9) < 8) begin
      w.in_if = ($urandom_range(1) == 0) ? 8'd0 : w.in_if;
      w.proto_id = 8'd0;
      w.src_port = ($urandom_range(2) == 0) ? w.src_port : 16'd0;
      w.dst_port = ($urandom_range(2) == 0) ? w.dst_port : 16'd0;
    end
    if ($urandom_range(1) == 0) w.src_addr = {8'd10, 8'($urandom_range(1)), w.src_addr[15:0]};
    if ($urandom_range(1) == 0) w.dst_addr = {8'd10, 8'($urandom_range(1)), w.dst_addr[15:0]};
    if (op != fwrc_pkg::OP_PACKET) begin
      if ($urandom_range(2) == 0) w.src_match = {w.src_match[6], 6'd63};
      else if ($urandom_range(1) == 0) begin
        w.src_match = {w.src_match[6], 6'd16};
        w.src_addr[15:0] = 16'd0;
      end
      if ($urandom_range(2) == 0) w.dst_match = {w.dst_match[6], 6'd63};
      else if ($urandom_range(1) == 0) begin
        w.dst_match = {w.dst_match[6], 6'd16};
        w.dst_addr[15:0] = 16'd0;
      end
    end
    return w;
  endfunction

  // directed rows: op, chain, in_if, out_if, src, dst, len, smatch, dmatch;
  // fixed expectations only where the result is plain (empty chains, extremes)
  typedef struct {
    fwrc_pkg::in_word_t w;
    bit chk;
    fwrc_pkg::out_word_t want;
  } row_t;

  row_t directed_rows[$];

  task automatic add_row(fwrc_pkg::in_word_t w, bit chk, fwrc_pkg::out_word_t want);
    row_t r;
    r.w = w;
    r.chk = chk;
    r.want = want;
    directed_rows.insert(directed_rows.size(), r);
  endtask

  function automatic fwrc_pkg::in_word_t dw(fwrc_pkg::op_t op, logic [1:0] ch,
                                            logic [7:0] ii, logic [7:0] oi,
                                            logic [31:0] sa, logic [31:0] da,
                                            logic [15:0] len, logic [6:0] sm,
                                            logic [6:0] dm);
    fwrc_pkg::in_word_t w;
    w = '0;
    w.operation = op; w.chain_select = ch; w.in_if = ii; w.out_if = oi;
    w.src_addr = sa; w.dst_addr = da; w.length = len;
    w.src_match = sm; w.dst_match = dm;
    return w;
  endfunction

  initial begin
    fwrc_pkg::in_word_t w;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b1;
    rst_n = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      sh_cnt[i] = 0; sh_cpk[i] = '0; sh_cby[i] = '0;
    end
    for (int i = 0; i < NCH*NRULE; i++) begin
      sh_rpk[i] = '0; sh_rby[i] = '0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty chains, extremes, every op, prefix cases, list, flush, zero
    add_row(dw(fwrc_pkg::OP_LIST, 2'd0, '0, '0, '0, '0, '0, '0, '0), 1'b1,
            mk(fwrc_pkg::KIND_TOTALS, NO_IDX, 32'd0, 32'd0, fwrc_pkg::ST_TERM, 1'b1));
    add_row(dw(fwrc_pkg::OP_PACKET, 2'd0, 8'hFF, 8'h00, '1, '1, 16'hFFFF, '0, '0), 1'b1,
            mk(fwrc_pkg::KIND_VERDICT, NO_IDX, 32'd1, 32'd65535, fwrc_pkg::ST_END, 1'b1));
    add_row(dw(fwrc_pkg::OP_PACKET, 2'd0, 8'h00, 8'hFF, '0, '0, 16'hFFFF, '0, '0), 1'b1,
            mk(fwrc_pkg::KIND_VERDICT, NO_IDX, 32'd1, 32'd65535, fwrc_pkg::ST_END, 1'b1));
    add_row(dw(fwrc_pkg::OP_PACKET, 2'd0, 8'hFF, 8'hFF, '0, '0, '0, '0, '0), 1'b1,
            mk(fwrc_pkg::KIND_VERDICT, NO_IDX, 32'd1, 32'd0, fwrc_pkg::ST_END, 1'b1));
    add_row(dw(fwrc_pkg::OP_APPEND_LOG, 2'd0, '0, '0, '0, '0, '0, 7'd63, 7'd127), 1'b1,
            mk(fwrc_pkg::KIND_APPEND, 5'd0, 32'd0, 32'd0, fwrc_pkg::ST_TERM, 1'b1));
    add_row(dw(fwrc_pkg::OP_APPEND_RET, 2'd0, '0, '0, 32'h0A000000, '0, '0,
               7'd8, 7'd0), 1'b0, '0);
    add_row(dw(fwrc_pkg::OP_APPEND_TERM, 2'd0, '0, '0, 32'hC0A80001, '0, '0,
               7'd40, 7'd63), 1'b0, '0);
    add_row(dw(fwrc_pkg::OP_APPEND_TERM, 2'd3, 8'd5, '0, 32'h0A000000, '0, '0,
               7'd72, 7'd63), 1'b0, '0);
    add_row(dw(fwrc_pkg::OP_PACKET, 2'd0, 8'd1, '0, 32'h0A010203, '0, 16'd100, '0, '0),
            1'b0, '0);
    add_row(dw(fwrc_pkg::OP_PACKET, 2'd0, 8'd1, '0, 32'hC0A80001, '0, 16'hFFFF, '0, '0),
            1'b0, '0);
    add_row(dw(fwrc_pkg::OP_PACKET, 2'd0, 8'd1, '0, 32'h01010101, '0, 16'd7, '0, '0),
            1'b0, '0);
    add_row(dw(fwrc_pkg::OP_PACKET, 2'd1, 8'd5, 8'd9, 32'h0B000000, '0, 16'd3, '0, '0),
            1'b0, '0);
    add_row(dw(fwrc_pkg::OP_PACKET, 2'd1, 8'd5, 8'd9, 32'h0A000000, '0, 16'd3, '0, '0),
            1'b0, '0);
    add_row(dw(fwrc_pkg::OP_LIST, 2'd0, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(dw(fwrc_pkg::OP_LIST, 2'd3, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(dw(fwrc_pkg::OP_NONE, 2'd0, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(dw(fwrc_pkg::OP_ZERO, 2'd0, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(dw(fwrc_pkg::OP_LIST, 2'd0, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(dw(fwrc_pkg::OP_FLUSH, 2'd2, '0, '0, '0, '0, '0, '0, '0), 1'b1,
            mk(fwrc_pkg::KIND_TOTALS, NO_IDX, 32'd0, 32'd0, fwrc_pkg::ST_TERM, 1'b1));
    add_row(dw(fwrc_pkg::OP_FLUSH, 2'd0, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].chk, directed_rows[i].want);
    // fill chain 1 past its end to hit the full case
    for (int i = 0; i < NRULE + 2; i++)
      send_word(dw(fwrc_pkg::OP_APPEND_LOG, 2'd1, 8'd200, '0, '0, '0, '0, 7'd63, 7'd63),
                i >= NRULE,
                mk(fwrc_pkg::KIND_APPEND, NO_IDX, 32'd0, 32'd0, fwrc_pkg::ST_FULL, 1'b1));
    drain();
    send_word(dw(fwrc_pkg::OP_LIST, 2'd1, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    send_word(dw(fwrc_pkg::OP_FLUSH, 2'd1, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    drain();

    // random: three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 38 : 0;
      for (int n = 0; n < 170; n++) begin
        case ($urandom_range(99)) inside
          [0:54]: w = shaped_word(fwrc_pkg::OP_PACKET);
          [55:79]: w = shaped_word(3'($urandom_range(fwrc_pkg::OP_APPEND_LOG,
                                                     fwrc_pkg::OP_APPEND_TERM)));
          [80:83]: w = shaped_word(fwrc_pkg::OP_FLUSH);
          [84:87]: w = shaped_word(fwrc_pkg::OP_ZERO);
          [88:93]: w = shaped_word(fwrc_pkg::OP_LIST);
          [94:96]: w = rand_word();
          default: w = shaped_word(fwrc_pkg::OP_NONE);
        endcase
        if (n == 85) drain();
        send_word(w, 1'b0, '0);
      end
    end
    drain();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
design/fwrc_pkg.sv
design/fwrc_ram.sv
design/fwrc_datapath.sv
design/fwrc_ctrl.sv
design/firewall_rule_chain_classifier_core.sv
sim/firewall_rule_chain_classifier_core_tb.sv
